>>> rtl/core/pwct_pkg.sv
package pwct_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SCALE_W = 8;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // tdata layouts: four coordinates, color, mode, zero pad to whole bytes
    localparam int unsigned S_TDATA_W = 104;
    localparam int unsigned M_TDATA_W = 104;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SET_WINDOW = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STREAM_PIX = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EXPLICIT   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;

    // two opposite corners of a rectangle (a pixel has both equal)
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } corners_t;

    // corners picked by the cursor logic, with the mode they carry
    typedef struct packed {
        logic                emit;
        corners_t            corners;
        logic [MODE_W-1:0]   mode;
    } pick_t;

    // normalized output rectangle
    typedef struct packed {
        coord_t x_min;
        coord_t y_min;
        coord_t x_max;
        coord_t y_max;
    } rect_t;

endpackage

>>> rtl/core/pwct_cursor.sv
module pwct_cursor (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [pwct_pkg::ACT_W-1:0]  action,
    input  pwct_pkg::corners_t      item_corners,
    input  logic [pwct_pkg::MODE_W-1:0] blend_mode,
    output pwct_pkg::pick_t         pick
);
    import pwct_pkg::*;

    coord_t            window_left_reg,  window_left_next;
    coord_t            window_right_reg, window_right_next;
    coord_t            cursor_x_reg,     cursor_x_next;
    coord_t            cursor_y_reg,     cursor_y_next;
    logic [MODE_W-1:0] window_mode_reg,  window_mode_next;

    always_comb begin
        pick.emit    = 1'b0;
        pick.corners = item_corners;
        pick.mode    = blend_mode;
        case (action)
            ACT_STREAM_PIX: begin
                pick.emit       = 1'b1;
                pick.corners.x0 = cursor_x_reg;
                pick.corners.y0 = cursor_y_reg;
                pick.corners.x1 = cursor_x_reg;
                pick.corners.y1 = cursor_y_reg;
                pick.mode       = window_mode_reg;
            end
            ACT_EXPLICIT: begin
                pick.emit = 1'b1;
            end
            default: begin
                pick.emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        window_left_next  = window_left_reg;
        window_right_next = window_right_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        window_mode_next  = window_mode_reg;
        if (accept) begin
            case (action)
                ACT_SET_WINDOW: begin
                    // bottom edge is not kept; the cursor never stops on y
                    window_left_next  = item_corners.x0;
                    window_right_next = item_corners.x1;
                    window_mode_next  = blend_mode;
                    cursor_x_next     = item_corners.x0;
                    cursor_y_next     = item_corners.y0;
                end
                ACT_STREAM_PIX: begin
                    if (cursor_x_reg < window_right_reg) begin
                        cursor_x_next = cursor_x_reg + coord_t'(1);
                    end else begin
                        cursor_x_next = window_left_reg;
                        cursor_y_next = cursor_y_reg + coord_t'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_left_reg  <= '0;
            window_right_reg <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            window_mode_reg  <= '0;
        end else begin
            window_left_reg  <= window_left_next;
            window_right_reg <= window_right_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            window_mode_reg  <= window_mode_next;
        end
    end

endmodule

>>> rtl/core/pwct_axis_map.sv
module pwct_axis_map (
    input  pwct_pkg::coord_t                    lo,
    input  pwct_pkg::coord_t                    hi,
    input  logic signed [pwct_pkg::SCALE_W-1:0] scale,
    input  pwct_pkg::coord_t                    offset,
    output pwct_pkg::coord_t                    mn,
    output pwct_pkg::coord_t                    mx
);
    import pwct_pkg::*;

    localparam int unsigned PROD_W = COORD_W + SCALE_W;

    coord_t                    hi_inc;
    logic signed [PROD_W-1:0]  prod_a;
    logic signed [PROD_W-1:0]  prod_b;
    coord_t                    edge_a;
    coord_t                    edge_b;

    // edge_b is the exclusive far edge; only the low 16 bits matter
    assign hi_inc = hi + coord_t'(1);
    assign prod_a = PROD_W'(lo) * PROD_W'(scale);
    assign prod_b = PROD_W'(hi_inc) * PROD_W'(scale);
    assign edge_a = prod_a[COORD_W-1:0] + offset;
    assign edge_b = prod_b[COORD_W-1:0] + offset;

    always_comb begin
        if (edge_b > edge_a) begin
            mn = edge_a;
            mx = edge_b - coord_t'(1);
        end else begin
            // mirrored or zero scale: zero gives min = max + 1, an empty rect
            mn = edge_b + coord_t'(1);
            mx = edge_a;
        end
    end

endmodule

>>> rtl/core/pixel_window_coordinate_transform.sv
// Pixel window coordinate transform.
//
// s_ channel: one beat per command. s_tuser carries the action (set window,
// stream pixel at cursor, explicit rectangle), s_tlast the end-of-batch flag.
// A set-window beat only loads the window, mode and cursor and yields no
// output; an unknown action is dropped. Every pixel or rectangle beat yields
// one m_ beat with the swapped, scaled, offset and normalized rectangle,
// plus color, mode and the copied tlast.
// cfg_ port: register writes (swap, scales, offsets), always ready. Write it
// only while the stream is idle.
// Pipeline: input stage register, then result register; an accepted beat
// moves from the input stage into the result register, which drives m_,
// once that register is free or being drained. Throughput: one beat per
// cycle unless m_tready stalls; the cursor update is a combinational
// add/compare; each axis has two 16x8 multiplies between the two registers.
// Reset (aresetn low, synchronous): config returns to unit scale, no swap,
// zero offset; window and cursor clear to zero; both stages empty.
// A stalled m_tready holds the result register; the input stage still takes
// one more beat, then s_tready drops until the result is taken.
module pixel_window_coordinate_transform (
    input  logic                               aclk,
    input  logic                               aresetn,
    // first_x, first_y, last_x, last_y, pixel_color, blend_mode, zero pad
    input  logic [pwct_pkg::S_TDATA_W-1:0]     s_tdata,
    // action
    input  logic [pwct_pkg::ACT_W-1:0]         s_tuser,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // out_x_min, out_y_min, out_x_max, out_y_max, out_color, out_mode, zero pad
    output logic [pwct_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwct_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pwct_pkg::*;

    localparam int unsigned M_PAD_W = M_TDATA_W - 4 * COORD_W - COLOR_W - MODE_W;

    // ---- configuration registers
    logic                       swap_axes_reg;
    logic signed [SCALE_W-1:0]  scale_x_reg;
    logic signed [SCALE_W-1:0]  scale_y_reg;
    coord_t                     offset_x_reg;
    coord_t                     offset_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_axes_reg <= 1'b0;
            scale_x_reg   <= SCALE_W'(1);
            scale_y_reg   <= SCALE_W'(1);
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SWAP_AXES: swap_axes_reg <= cfg_data[0];
                CFG_SCALE_X:   scale_x_reg   <= cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:   scale_y_reg   <= cfg_data[SCALE_W-1:0];
                CFG_OFFSET_X:  offset_x_reg  <= cfg_data[COORD_W-1:0];
                CFG_OFFSET_Y:  offset_y_reg  <= cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---- input unpack and cursor
    corners_t          in_corners;
    logic [COLOR_W-1:0] in_color;
    logic [MODE_W-1:0]  in_mode;
    logic               s_accept;
    pick_t              pick;
    corners_t           swapped;

    assign in_corners.x0 = s_tdata[15:0];
    assign in_corners.y0 = s_tdata[31:16];
    assign in_corners.x1 = s_tdata[47:32];
    assign in_corners.y1 = s_tdata[63:48];
    assign in_color      = s_tdata[95:64];
    assign in_mode       = s_tdata[99:96];

    assign s_accept = s_tvalid & s_tready;

    pwct_cursor u_cursor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .action       (s_tuser),
        .item_corners (in_corners),
        .blend_mode   (in_mode),
        .pick         (pick)
    );

    always_comb begin
        swapped = pick.corners;
        if (swap_axes_reg) begin
            swapped.x0 = pick.corners.y0;
            swapped.y0 = pick.corners.x0;
            swapped.x1 = pick.corners.y1;
            swapped.y1 = pick.corners.x1;
        end
    end

    // ---- input stage register
    logic               s1_valid_reg;
    corners_t           s1_corners_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic [MODE_W-1:0]  s1_mode_reg;
    logic               s1_last_reg;
    logic               s1_advance;

    // stage 1 moves on when the result register is free or being drained
    assign s1_advance = !m_tvalid || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_accept & pick.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_corners_reg <= swapped;
            s1_color_reg   <= in_color;
            s1_mode_reg    <= pick.mode;
            s1_last_reg    <= s_tlast;
        end
    end

    // ---- scale, offset and normalize, one unit per axis
    rect_t rect;

    pwct_axis_map u_map_x (
        .lo     (s1_corners_reg.x0),
        .hi     (s1_corners_reg.x1),
        .scale  (scale_x_reg),
        .offset (offset_x_reg),
        .mn     (rect.x_min),
        .mx     (rect.x_max)
    );

    pwct_axis_map u_map_y (
        .lo     (s1_corners_reg.y0),
        .hi     (s1_corners_reg.y1),
        .scale  (scale_y_reg),
        .offset (offset_y_reg),
        .mn     (rect.y_min),
        .mx     (rect.y_max)
    );

    // ---- result register
    logic               m_valid_reg;
    rect_t              m_rect_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic [MODE_W-1:0]  m_mode_reg;
    logic               m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_rect_reg  <= rect;
            m_color_reg <= s1_color_reg;
            m_mode_reg  <= s1_mode_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_mode_reg, m_color_reg,
                       m_rect_reg.y_max, m_rect_reg.x_max,
                       m_rect_reg.y_min, m_rect_reg.x_min};

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pwct_pkg::*;

    // action code the block must drop without a beat or a state change
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int NDIR       = 18;
    localparam int NPHASE     = 7;    // fixed settings, then two random ones
    localparam int PHASE_CMDS = 120;  // counted commands per setting
    localparam int STALL_MAX  = 2000; // cycles without any beat before giving up

    // one command beat on the s_ side
    typedef struct packed {
        logic [ACT_W-1:0]   act;
        coord_t             fx;
        coord_t             fy;
        coord_t             lx;
        coord_t             ly;
        logic [COLOR_W-1:0] color;
        logic [MODE_W-1:0]  mode;
        logic               last;
    } cmd_t;

    // one expected beat on the m_ side
    typedef struct {
        coord_t             x_min;
        coord_t             y_min;
        coord_t             x_max;
        coord_t             y_max;
        logic [COLOR_W-1:0] color;
        logic [MODE_W-1:0]  mode;
        logic               last;
    } rect_beat_t;

    // directed row: command plus, where obvious, the rectangle and mode typed in
    typedef struct packed {
        cmd_t              cmd;
        logic              typed;
        coord_t            t_x_min;
        coord_t            t_y_min;
        coord_t            t_x_max;
        coord_t            t_y_max;
        logic [MODE_W-1:0] t_mode;
    } dir_row_t;

    typedef struct packed {
        logic                     swap;
        logic signed [SCALE_W-1:0] kx;
        logic signed [SCALE_W-1:0] ky;
        coord_t                   ox;
        coord_t                   oy;
    } xform_t;

    // Directed part, runs on the reset configuration (unit scale, no swap).
    // Stream pixels start on the cleared window, so the first two land on
    // (0,0) and then (0,1): window_right is 0, so the cursor steps a row.
    localparam dir_row_t DIR_TAB [NDIR] = '{
        '{'{ACT_STREAM_PIX, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0,
            32'hffff_ffff, 4'hf, 1'b1}, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h0, 4'h0, 1'b0}, 1'b1, 16'h0, 16'h1, 16'h0, 16'h1, 4'h0},
        '{'{ACT_EXPLICIT, 16'h5, 16'h7, 16'h5, 16'h7,
            32'ha5a5_5a5a, 4'hf, 1'b1}, 1'b1, 16'h5, 16'h7, 16'h5, 16'h7, 4'hf},
        // max corner: hi+1 wraps to the most negative value
        '{'{ACT_EXPLICIT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
            32'h0, 4'h0, 1'b0}, 1'b1, 16'h8001, 16'h8001, 16'h7fff, 16'h7fff, 4'h0},
        // full range rectangle collapses through the wrap
        '{'{ACT_EXPLICIT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
            32'hffff_ffff, 4'h5, 1'b1}, 1'b1, 16'h8001, 16'h8001, 16'h8000, 16'h8000,
            4'h5},
        '{'{ACT_EXPLICIT, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            32'h0f0f_f0f0, 4'ha, 1'b0}, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            4'ha},
        // unknown action: no beat, no state change
        '{'{ACT_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            32'hffff_ffff, 4'hf, 1'b1}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_SET_WINDOW, 16'd10, 16'd20, 16'd12, 16'd99,
            32'h1111_1111, 4'h9, 1'b0}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h0000_0001, 4'h0, 1'b0}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h0000_0002, 4'h0, 1'b0}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h0000_0003, 4'h0, 1'b0}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h0000_0004, 4'h0, 1'b1}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        // right edge left of left edge: one row per pixel
        '{'{ACT_SET_WINDOW, 16'd5, 16'hfffd, 16'hfffb, 16'h0,
            32'h0, 4'h6, 1'b0}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h8000_0000, 4'h0, 1'b0}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h7fff_ffff, 4'h0, 1'b1}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        // corners given in reverse order still normalize
        '{'{ACT_EXPLICIT, 16'd10, 16'd10, 16'd2, 16'd3,
            32'h0, 4'h3, 1'b0}, 1'b1, 16'd4, 16'd5, 16'd10, 16'd10, 4'h3},
        // cursor parked at the top x value, then steps to the next row
        '{'{ACT_SET_WINDOW, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
            32'h0, 4'h1, 1'b0}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0},
        '{'{ACT_STREAM_PIX, 16'h0, 16'h0, 16'h0, 16'h0,
            32'h0, 4'h0, 1'b1}, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0}
    };

    // Settings walked after the directed part: mirror, zero scale, extremes.
    localparam xform_t PHASES [NPHASE] = '{
        '{1'b1, 8'sd3,  -8'sd2,  16'sd100,  -16'sd50},
        '{1'b0, 8'sd0,  8'sd0,   16'sd1234, -16'sd1234},
        '{1'b1, -8'sd64, 8'sd64, 16'h8000,  16'h7fff},
        '{1'b0, 8'sd64, -8'sd64, 16'h7fff,  16'h8000},
        '{1'b0, -8'sd1, -8'sd1,  16'h0,     16'h0},
        '{1'b1, 8'sd1,  8'sd1,   -16'sd1,   16'sd1},
        '{1'b0, 8'sd1,  8'sd1,   16'h0,     16'h0}
    };

    // ---------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [ACT_W-1:0]      s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pixel_window_coordinate_transform u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Predictor state: transform registers plus window/cursor, reset values
    // ---------------------------------------------------------------------
    logic                      xf_swap = 1'b0;
    logic signed [SCALE_W-1:0] xf_kx   = 8'sd1;
    logic signed [SCALE_W-1:0] xf_ky   = 8'sd1;
    coord_t                    xf_ox   = '0;
    coord_t                    xf_oy   = '0;
    coord_t                    win_left  = '0;
    coord_t                    win_right = '0;
    coord_t                    cur_x     = '0;
    coord_t                    cur_y     = '0;
    logic [MODE_W-1:0]         win_mode  = '0;

    rect_beat_t pending_rects [$];   // oldest expected m_ beat at the front
    int         err_cnt = 0;

    // Scale and offset one axis, then order the edges. The far edge is
    // hi+1 scaled, so the output spans whole scaled pixels; all 16-bit wrap.
    function automatic void map_span(input coord_t lo, input coord_t hi,
                                     input logic signed [SCALE_W-1:0] k,
                                     input coord_t off,
                                     output coord_t lo_out, output coord_t hi_out);
        int     a_w;
        int     b_w;
        coord_t a;
        coord_t b;
        a_w = int'(lo) * int'(k) + int'(off);
        b_w = (int'(hi) + 1) * int'(k) + int'(off);
        a = coord_t'(a_w);
        b = coord_t'(b_w);
        if (b > a) begin
            lo_out = a;
            hi_out = b - 16'sd1;
        end else begin
            // zero scale lands here: min = off+1 above max = off
            lo_out = b + 16'sd1;
            hi_out = a;
        end
    endfunction

    // Advance window/cursor state for one command; returns 1 with the
    // expected beat when the command yields one.
    function automatic bit predict_rect(input cmd_t c, output rect_beat_t e);
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        coord_t t;
        bit     yields;
        yields  = 1'b1;
        e.color = c.color;
        e.last  = c.last;
        case (c.act)
            ACT_SET_WINDOW: begin
                // bottom edge (ly) is not kept
                win_left  = c.fx;
                win_right = c.lx;
                win_mode  = c.mode;
                cur_x     = c.fx;
                cur_y     = c.fy;
                yields    = 1'b0;
            end
            ACT_STREAM_PIX: begin
                x0 = cur_x;
                y0 = cur_y;
                x1 = cur_x;
                y1 = cur_y;
                e.mode = win_mode;
                if (cur_x < win_right) begin
                    cur_x = cur_x + 16'sd1;
                end else begin
                    cur_x = win_left;
                    cur_y = cur_y + 16'sd1;
                end
            end
            ACT_EXPLICIT: begin
                x0 = c.fx;
                y0 = c.fy;
                x1 = c.lx;
                y1 = c.ly;
                e.mode = c.mode;
            end
            default: yields = 1'b0;
        endcase
        if (yields) begin
            if (xf_swap) begin
                t = x0; x0 = y0; y0 = t;
                t = x1; x1 = y1; y1 = t;
            end
            map_span(x0, x1, xf_kx, xf_ox, e.x_min, e.x_max);
            map_span(y0, y1, xf_ky, xf_oy, e.y_min, e.y_max);
        end
        return yields;
    endfunction

    // ---------------------------------------------------------------------
    // Random command generation
    // ---------------------------------------------------------------------
    // mostly small values near the origin, some full range, some extremes
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            1, 2, 3: return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(0, 128)) - 64);
        endcase
    endfunction

    // Mostly pixels streamed through small windows with a set-window now and
    // then, explicit rectangles with sane corners, plus noise.
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   pick;
        pick    = $urandom_range(0, 99);
        c.color = $urandom;
        c.mode  = MODE_W'($urandom);
        c.last  = ($urandom_range(0, 7) == 0);
        c.fx    = rand_coord();
        c.fy    = rand_coord();
        c.lx    = rand_coord();
        c.ly    = rand_coord();
        if (pick < 9) begin
            c.act = ACT_SET_WINDOW;
            if ($urandom_range(0, 9) != 0)
                c.lx = c.fx + coord_t'($urandom_range(0, 7));
        end else if (pick < 60) begin
            c.act = ACT_STREAM_PIX;
        end else if (pick < 96) begin
            c.act = ACT_EXPLICIT;
            if ($urandom_range(0, 9) < 7) begin
                c.lx = c.fx + coord_t'($urandom_range(0, 15));
                c.ly = c.fy + coord_t'($urandom_range(0, 15));
            end
        end else begin
            c.act = ACT_UNUSED;
        end
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------------
    // Present one beat and hold it until accepted; valid stays high so the
    // caller decides whether a gap follows.
    task automatic send_cmd(input cmd_t c, output bit yields, output rect_beat_t e);
        s_tdata  <= {4'b0, c.mode, c.color, c.ly, c.lx, c.fy, c.fx};
        s_tuser  <= c.act;
        s_tlast  <= c.last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        yields = predict_rect(c, e);
    endtask

    // bursts of random length with random gaps between them
    task automatic pace(inout int burst_left);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // sender pauses until every expected beat is out, then lets the
    // two-stage pipe settle (a set-window beat leaves nothing to wait on)
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_rects.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SWAP_AXES: xf_swap = val[0];
            CFG_SCALE_X:   xf_kx   = val[SCALE_W-1:0];
            CFG_SCALE_Y:   xf_ky   = val[SCALE_W-1:0];
            CFG_OFFSET_X:  xf_ox   = val;
            CFG_OFFSET_Y:  xf_oy   = val;
            default: ;
        endcase
    endtask

    // write all five registers back to back; scales go out sign extended
    task automatic program_xform(input xform_t xf);
        cfg_write(CFG_SWAP_AXES, {15'b0, xf.swap});
        cfg_write(CFG_SCALE_X, {{8{xf.kx[7]}}, xf.kx});
        cfg_write(CFG_SCALE_Y, {{8{xf.ky[7]}}, xf.ky});
        cfg_write(CFG_OFFSET_X, xf.ox);
        cfg_write(CFG_OFFSET_Y, xf.oy);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        cmd_t       c;
        rect_beat_t e;
        bit         yields;
        int         burst_left;
        int         counted;
        xform_t     xf;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        burst_left = $urandom_range(1, 30);

        // directed rows on the reset configuration
        for (int i = 0; i < NDIR; i++) begin
            send_cmd(DIR_TAB[i].cmd, yields, e);
            if (yields) begin
                if (DIR_TAB[i].typed) begin
                    e.x_min = DIR_TAB[i].t_x_min;
                    e.y_min = DIR_TAB[i].t_y_min;
                    e.x_max = DIR_TAB[i].t_x_max;
                    e.y_max = DIR_TAB[i].t_y_max;
                    e.mode  = DIR_TAB[i].t_mode;
                end
                pending_rects.push_back(e);
            end
            pace(burst_left);
        end

        // random commands under each setting; the last two are random too
        for (int p = 0; p < NPHASE + 2; p++) begin
            drain();
            if (p < NPHASE) begin
                xf = PHASES[p];
            end else begin
                xf.swap = $urandom_range(0, 1);
                xf.kx   = SCALE_W'(int'($urandom_range(0, 128)) - 64);
                xf.ky   = SCALE_W'(int'($urandom_range(0, 128)) - 64);
                xf.ox   = coord_t'($urandom);
                xf.oy   = coord_t'($urandom);
            end
            program_xform(xf);
            counted = 0;
            while (counted < PHASE_CMDS) begin
                c = rand_cmd();
                send_cmd(c, yields, e);
                if (yields) pending_rects.push_back(e);
                if (c.act != ACT_UNUSED) counted++;
                if ($urandom_range(0, 199) == 0)
                    drain();
                else
                    pace(burst_left);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (err_cnt == 0 && pending_rects.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: m_tready cycles through always-ready, light random stall,
    // a fixed stall pattern and heavy random stall, in turn by rdy_cyc[9:8].
    // ---------------------------------------------------------------------
    logic [9:0] rdy_cyc = '0;

    always @(posedge aclk) begin
        rdy_cyc <= rdy_cyc + 10'd1;
        case (rdy_cyc[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (rdy_cyc[2:1] != 2'b11);
            default: m_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    // ---------------------------------------------------------------------
    // Result checker and watchdog
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt < 50)
                $display("%0t tb_top: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    int quiet_cycles = 0;

    always @(posedge aclk) begin
        rect_beat_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_rects.size() == 0) begin
                    err_cnt++;
                    if (err_cnt < 50)
                        $display("%0t tb_top: unexpected m_ beat, expected none, actual %h",
                                 $time, m_tdata);
                end else begin
                    want = pending_rects.pop_front();
                    check_field("x_min", int'(want.x_min), int'($signed(m_tdata[15:0])));
                    check_field("y_min", int'(want.y_min), int'($signed(m_tdata[31:16])));
                    check_field("x_max", int'(want.x_max), int'($signed(m_tdata[47:32])));
                    check_field("y_max", int'(want.y_max), int'($signed(m_tdata[63:48])));
                    check_field("color", int'(want.color), int'(m_tdata[95:64]));
                    check_field("mode", int'(want.mode), int'(m_tdata[99:96]));
                    check_field("last", int'(want.last), int'(m_tlast));
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_MAX) begin
                $display("tb_top: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
